FILE: hw/rtl/sobel_edge_magnitude_assert.svh
// Assertion macros shared by the Sobel edge magnitude checker.
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEM_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sobel edge magnitude: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SEM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sobel edge magnitude: next-cycle check failed");

`endif

FILE: hw/rtl/sem_pkg.sv
// Package with the constants and register codes of the Sobel edge magnitude block.
`timescale 1ns / 1ps
package sem_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned COL_W    = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W    = $clog2(MAX_HEIGHT);
  localparam int unsigned WIDTH_W  = 12;
  localparam int unsigned HEIGHT_W = 13;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned CFG_W    = 13;

  localparam logic [WIDTH_W-1:0]  LINE_WIDTH_RST   = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = HEIGHT_W'(480);
  localparam logic [WIDTH_W-1:0]  MIN_WIDTH        = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]  MAX_WIDTH_V      = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] MIN_HEIGHT       = HEIGHT_W'(3);
  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_V     = HEIGHT_W'(MAX_HEIGHT);

  localparam logic [PIX_W-1:0] MAG_SAT = 8'd255;

  localparam logic REG_LINE_WIDTH   = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

endpackage

FILE: hw/rtl/sem_ram.sv
// Simple dual-port line store with one write port and a registered read port.
`timescale 1ns / 1ps
module sem_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/sem_sqrt.sv
// Bit-pair square-root unit that resolves one result bit per cycle.
`timescale 1ns / 1ps
module sem_sqrt import sem_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [15:0]      radicand_i,
  output logic             done_o,
  output logic [PIX_W-1:0] root_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [15:0]      val_q, val_d;
  logic [10:0]      rem_q, rem_d;
  logic [PIX_W-1:0] root_q, root_d;
  logic [10:0]      rem_shift;
  logic [10:0]      trial;
  logic             fits;

  assign rem_shift = {rem_q[8:0], val_q[15:14]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign fits      = (rem_shift >= trial);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
      val_d  = radicand_i;
      rem_d  = 11'd0;
      root_d = '0;
    end else if (busy_q) begin
      val_d  = {val_q[13:0], 2'b00};
      rem_d  = fits ? (rem_shift - trial) : rem_shift;
      root_d = {root_q[PIX_W-2:0], fits};
      cnt_d  = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: hw/rtl/sobel_edge_magnitude.sv
// Top level of the Sobel 3x3 gradient magnitude filter.
`timescale 1ns / 1ps
// The filter takes 8-bit gray pixels in raster order and keeps the two previous rows in one
// line-store memory, two pixels wide per entry, with a registered read. For every interior
// pixel it returns the truncated root of gx*gx+gy*gy saturated at 255, together with the row
// and column of the window center; border pixels return nothing. One pixel is in work at a
// time: a border pixel is accepted, then read from and written back to the line store; an
// interior pixel goes on through the squaring and sum steps and, unless its magnitude
// saturates, through the square-root unit, which settles one result bit per cycle, before it
// reaches the output step. A finished result waits in an output register, so the next pixel
// is accepted while it waits. The line store has no reset and needs no clearing pass.
module sobel_edge_magnitude import sem_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                pixel_valid_i,
  output logic                pixel_ready_o,
  input  logic [PIX_W-1:0]    pixel_i,
  output logic                result_valid_o,
  input  logic                result_ready_i,
  output logic [PIX_W-1:0]    magnitude_o,
  output logic [ROW_W-1:0]    center_row_o,
  output logic [COL_W-1:0]    center_col_o,
  output logic                frame_done_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_SQUARE = 3'd2;
  localparam logic [2:0] ST_SUM    = 3'd3;
  localparam logic [2:0] ST_ROOT   = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [WIDTH_W-1:0]  line_width_q;
  logic [HEIGHT_W-1:0] frame_height_q;
  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    row_q;
  logic [PIX_W-1:0]    win_q [6];

  logic [PIX_W-1:0]    pix_q;
  logic [COL_W-1:0]    addr_q;
  logic                emit_q;
  logic [ROW_W-1:0]    crow_q;
  logic [COL_W-1:0]    ccol_q;
  logic                fdone_q;
  logic [9:0]          absx_q, absy_q;
  logic [19:0]         sqx_q, sqy_q;
  logic [PIX_W-1:0]    mag_q;

  logic                out_valid_q;
  logic [PIX_W-1:0]    out_mag_q;
  logic [ROW_W-1:0]    out_row_q;
  logic [COL_W-1:0]    out_col_q;
  logic                out_fdone_q;

  logic                accept;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic                last_col, last_row;
  logic [15:0]         rdata;
  logic [PIX_W-1:0]    top, mid;
  logic [9:0]          gx_pos, gx_neg, gy_pos, gy_neg;
  logic [9:0]          absx, absy;
  logic [20:0]         sum;
  logic                sat;
  logic                mem_we;
  logic                root_start;
  logic                root_done;
  logic [PIX_W-1:0]    root_val;
  logic                out_load;

  assign accept = pixel_valid_i && pixel_ready_o;
  assign pixel_ready_o = (state_q == ST_IDLE);

  always_comb begin
    if (line_width_q < MIN_WIDTH) begin
      w_eff = MIN_WIDTH;
    end else if (line_width_q > MAX_WIDTH_V) begin
      w_eff = MAX_WIDTH_V;
    end else begin
      w_eff = line_width_q;
    end
    if (frame_height_q < MIN_HEIGHT) begin
      h_eff = MIN_HEIGHT;
    end else if (frame_height_q > MAX_HEIGHT_V) begin
      h_eff = MAX_HEIGHT_V;
    end else begin
      h_eff = frame_height_q;
    end
  end

  assign last_col = (({1'b0, col_q} + WIDTH_W'(1)) >= w_eff);
  assign last_row = (({1'b0, row_q} + HEIGHT_W'(1)) >= h_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LINE_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LINE_WIDTH:   line_width_q   <= cfg_data_i[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign mem_we = (state_q == ST_READ);

  sem_ram #(
    .DEPTH(MAX_WIDTH),
    .WIDTH(2 * PIX_W)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(addr_q),
    .wdata_i({mid, pix_q}),
    .re_i   (accept),
    .raddr_i(col_q),
    .rdata_o(rdata)
  );

  assign top = rdata[2*PIX_W-1:PIX_W];
  assign mid = rdata[PIX_W-1:0];

  assign gx_pos = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, pix_q};
  assign gx_neg = {2'b00, win_q[0]} + {1'b0, win_q[1], 1'b0} + {2'b00, win_q[2]};
  assign gy_pos = {2'b00, win_q[2]} + {1'b0, win_q[5], 1'b0} + {2'b00, pix_q};
  assign gy_neg = {2'b00, win_q[0]} + {1'b0, win_q[3], 1'b0} + {2'b00, top};
  assign absx   = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
  assign absy   = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);

  assign sum = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign sat = (sum[20:16] != 5'd0);

  assign root_start = (state_q == ST_SUM) && !sat;

  sem_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (root_start),
    .radicand_i(sum[15:0]),
    .done_o    (root_done),
    .root_o    (root_val)
  );

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || result_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_READ;
      ST_READ:   state_d = emit_q ? ST_SQUARE : ST_IDLE;
      ST_SQUARE: state_d = ST_SUM;
      ST_SUM:    state_d = sat ? ST_OUT : ST_ROOT;
      ST_ROOT:   if (root_done) state_d = ST_OUT;
      ST_OUT:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (accept) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : (row_q + ROW_W'(1));
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
      if (state_q == ST_READ) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top;
        win_q[4] <= mid;
        win_q[5] <= pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q   <= pixel_i;
      addr_q  <= col_q;
      emit_q  <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
      crow_q  <= row_q - ROW_W'(1);
      ccol_q  <= col_q - COL_W'(1);
      fdone_q <= last_col && last_row;
    end
    if (state_q == ST_READ) begin
      absx_q <= absx;
      absy_q <= absy;
    end
    if (state_q == ST_SQUARE) begin
      sqx_q <= 20'(absx_q) * 20'(absx_q);
      sqy_q <= 20'(absy_q) * 20'(absy_q);
    end
    if ((state_q == ST_SUM) && sat) begin
      mag_q <= MAG_SAT;
    end else if ((state_q == ST_ROOT) && root_done) begin
      mag_q <= root_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mag_q   <= mag_q;
      out_row_q   <= crow_q;
      out_col_q   <= ccol_q;
      out_fdone_q <= fdone_q;
    end
  end

  assign result_valid_o = out_valid_q;
  assign magnitude_o    = out_mag_q;
  assign center_row_o   = out_row_q;
  assign center_col_o   = out_col_q;
  assign frame_done_o   = out_fdone_q;

endmodule

FILE: hw/rtl/sem_checker.sv
// Port-level checker for the Sobel edge magnitude block and its bind statement.
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_assert.svh"
module sem_checker import sem_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             pixel_valid_i,
  input logic             pixel_ready_o,
  input logic             result_valid_o,
  input logic             result_ready_i,
  input logic [PIX_W-1:0] magnitude_o,
  input logic [ROW_W-1:0] center_row_o,
  input logic [COL_W-1:0] center_col_o,
  input logic             frame_done_o
);

  logic [PIX_W+ROW_W+COL_W:0] result_payload;

  assign result_payload = {magnitude_o, center_row_o, center_col_o, frame_done_o};

  `SEM_ASSERT_NEXT(a_result_hold, result_valid_o && !result_ready_i, result_valid_o && $stable(result_payload))

  `SEM_ASSERT_NEXT(a_one_in_flight, pixel_valid_i && pixel_ready_o, !pixel_ready_o)

  `SEM_ASSERT_HOLDS(a_interior_only, result_valid_o, (center_row_o != '0) && (center_col_o != '0))

  `SEM_ASSERT_HOLDS(a_result_after_work, $rose(result_valid_o), !$past(pixel_ready_o))

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (.*);
